// ===== rtl/core/ppp_pkg.sv =====
`default_nettype none
package ppp_pkg;

	localparam int unsigned ZW = 31;
	localparam int unsigned QW = 49;
	localparam int unsigned WW = 48;
	localparam int unsigned AXIS_LAT = 6;
	localparam int unsigned CFG_IW = 3;

	localparam logic [CFG_IW-1:0] REG_X_SCALE = 3'd0;
	localparam logic [CFG_IW-1:0] REG_Y_SCALE = 3'd1;
	localparam logic [CFG_IW-1:0] REG_X_OFFSET = 3'd2;
	localparam logic [CFG_IW-1:0] REG_Y_OFFSET = 3'd3;

	localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic        last;
		logic        bad;
	} pay_t;

endpackage
`default_nettype wire

// ===== rtl/core/ppp_div_cell.sv =====
`default_nettype none
module ppp_div_cell #(
	parameter bit LEAD = 1'b0
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire [ppp_pkg::ZW-1:0]     in_z,
	input  wire [ppp_pkg::ZW-1:0]     in_rem,
	input  wire [ppp_pkg::QW-1:0]     in_quo,
	input  ppp_pkg::pay_t             in_pay,
	output logic                      out_valid,
	output logic [ppp_pkg::ZW-1:0]    out_z,
	output logic [ppp_pkg::ZW-1:0]    out_rem,
	output logic [ppp_pkg::QW-1:0]    out_quo,
	output ppp_pkg::pay_t             out_pay
);
	import ppp_pkg::*;

	logic [ZW:0] trial;
	logic [ZW:0] diff;
	logic        ge;

	assign trial = {in_rem, LEAD};
	assign diff = trial - {1'b0, in_z};
	assign ge = trial >= {1'b0, in_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_z <= in_z;
		out_rem <= ge ? diff[ZW-1:0] : trial[ZW-1:0];
		out_quo <= {in_quo[QW-2:0], ge};
		out_pay <= in_pay;
	end

endmodule
`default_nettype wire

// ===== rtl/core/ppp_axis.sv =====
`default_nettype none
module ppp_axis (
	input  wire                    clk,
	input  wire signed [31:0]      coord,
	input  wire signed [31:0]      scale,
	input  wire signed [31:0]      offset,
	input  wire [ppp_pkg::WW-1:0]  w,
	output logic signed [15:0]     screen,
	output logic                   clamp
);
	import ppp_pkg::*;

	logic [31:0]        mc;
	logic [31:0]        ms;
	logic [63:0]        p_s1;
	logic               neg_s1;
	logic [WW-1:0]      w_s1;
	logic [63:0]        pp00_s2;
	logic [47:0]        pp01_s2;
	logic [63:0]        pp10_s2;
	logic [47:0]        pp11_s2;
	logic               neg_s2;
	logic [79:0]        sa_s3;
	logic [79:0]        sb_s3;
	logic               neg_s3;
	logic [111:0]       tot;
	logic [61:0]        mag_s4;
	logic               neg_s4;
	logic signed [63:0] smag;
	logic signed [63:0] sum_s5;
	logic signed [47:0] q;

	assign mc = coord[31] ? 32'(-coord) : 32'(coord);
	assign ms = scale[31] ? 32'(-scale) : 32'(scale);
	assign tot = {32'd0, sa_s3} + {sb_s3, 32'd0};
	assign smag = neg_s4 ? -$signed({2'b00, mag_s4}) : $signed({2'b00, mag_s4});
	assign q = 48'(sum_s5 >>> 16)
		+ 48'((sum_s5[63] && (sum_s5[15:0] != 16'd0)) ? 1 : 0);

	always_ff @(posedge clk) begin
		p_s1 <= 64'(mc) * 64'(ms);
		neg_s1 <= coord[31] ^ scale[31];
		w_s1 <= w;

		pp00_s2 <= 64'(p_s1[31:0]) * 64'(w_s1[31:0]);
		pp01_s2 <= 48'(p_s1[31:0]) * 48'(w_s1[47:32]);
		pp10_s2 <= 64'(p_s1[63:32]) * 64'(w_s1[31:0]);
		pp11_s2 <= 48'(p_s1[63:32]) * 48'(w_s1[47:32]);
		neg_s2 <= neg_s1;

		sa_s3 <= {16'd0, pp00_s2} + {pp01_s2, 32'd0};
		sb_s3 <= {16'd0, pp10_s2} + {pp11_s2, 32'd0};
		neg_s3 <= neg_s2;

		mag_s4 <= tot[109:48];
		neg_s4 <= neg_s3;

		sum_s5 <= smag + 64'(offset);

		if (q > 48'sd32767) begin
			screen <= 16'sh7fff;
			clamp <= 1'b1;
		end else if (q < -48'sd32768) begin
			screen <= 16'sh8000;
			clamp <= 1'b1;
		end else begin
			screen <= q[15:0];
			clamp <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/perspective_point_projection.sv =====
// An accepted request reaches its result strobe through 49 reciprocal cells, one
// quotient bit each, and then 6 projection stages.
// Throughput: one request per cycle; busy stays low.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset clears all valid bits and loads the scales with 1.0 and the offsets with 0.
`default_nettype none
module perspective_point_projection (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire signed [31:0]            point_x,
	input  wire signed [31:0]            point_y,
	input  wire signed [31:0]            point_z,
	input  wire                          last_point,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [ppp_pkg::CFG_IW-1:0]    cfg_index,
	input  wire [31:0]                   cfg_data,
	output logic                         strobe,
	output logic signed [15:0]           screen_x,
	output logic signed [15:0]           screen_y,
	output logic [47:0]                  inv_depth,
	output logic                         bad_depth,
	output logic                         clamped,
	output logic                         last_out
);
	import ppp_pkg::*;

	logic [31:0] x_scale_q;
	logic [31:0] y_scale_q;
	logic [31:0] x_offset_q;
	logic [31:0] y_offset_q;

	logic          c_valid [QW+1];
	logic [ZW-1:0] c_z     [QW+1];
	logic [ZW-1:0] c_rem   [QW+1];
	logic [QW-1:0] c_quo   [QW+1];
	pay_t          c_pay   [QW+1];

	logic [WW-1:0] w;
	logic          wsat;

	logic          v_q    [AXIS_LAT];
	logic          bad_q  [AXIS_LAT];
	logic          last_q [AXIS_LAT];
	logic          wsat_q [AXIS_LAT];
	logic [WW-1:0] w_q    [AXIS_LAT];

	logic signed [15:0] sx;
	logic signed [15:0] sy;
	logic               cx;
	logic               cy;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q <= SCALE_ONE;
			y_scale_q <= SCALE_ONE;
			x_offset_q <= 32'd0;
			y_offset_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_SCALE:  x_scale_q <= cfg_data;
				REG_Y_SCALE:  y_scale_q <= cfg_data;
				REG_X_OFFSET: x_offset_q <= cfg_data;
				REG_Y_OFFSET: y_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign c_valid[0] = start && !busy;
	assign c_z[0] = point_z[ZW-1:0];
	assign c_rem[0] = '0;
	assign c_quo[0] = '0;
	assign c_pay[0] = '{px: point_x, py: point_y, last: last_point,
		bad: point_z[31] || (point_z == 32'sd0)};

	for (genvar i = 0; i < QW; i++) begin : g_cell
		ppp_div_cell #(.LEAD(i == 0)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_z      (c_z[i]),
			.in_rem    (c_rem[i]),
			.in_quo    (c_quo[i]),
			.in_pay    (c_pay[i]),
			.out_valid (c_valid[i+1]),
			.out_z     (c_z[i+1]),
			.out_rem   (c_rem[i+1]),
			.out_quo   (c_quo[i+1]),
			.out_pay   (c_pay[i+1])
		);
	end

	assign wsat = c_quo[QW][QW-1];
	assign w = wsat ? {WW{1'b1}} : c_quo[QW][WW-1:0];

	ppp_axis u_axis_x (
		.clk    (clk),
		.coord  (c_pay[QW].px),
		.scale  (x_scale_q),
		.offset (x_offset_q),
		.w      (w),
		.screen (sx),
		.clamp  (cx)
	);

	ppp_axis u_axis_y (
		.clk    (clk),
		.coord  (c_pay[QW].py),
		.scale  (y_scale_q),
		.offset (y_offset_q),
		.w      (w),
		.screen (sy),
		.clamp  (cy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXIS_LAT; i++) begin
				v_q[i] <= 1'b0;
			end
		end else begin
			v_q[0] <= c_valid[QW];
			for (int i = 1; i < AXIS_LAT; i++) begin
				v_q[i] <= v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		bad_q[0] <= c_pay[QW].bad;
		last_q[0] <= c_pay[QW].last;
		wsat_q[0] <= wsat;
		w_q[0] <= w;
		for (int i = 1; i < AXIS_LAT; i++) begin
			bad_q[i] <= bad_q[i-1];
			last_q[i] <= last_q[i-1];
			wsat_q[i] <= wsat_q[i-1];
			w_q[i] <= w_q[i-1];
		end
	end

	assign strobe = v_q[AXIS_LAT-1];
	assign bad_depth = bad_q[AXIS_LAT-1];
	assign last_out = last_q[AXIS_LAT-1];
	assign screen_x = bad_depth ? 16'sd0 : sx;
	assign screen_y = bad_depth ? 16'sd0 : sy;
	assign inv_depth = bad_depth ? 48'd0 : w_q[AXIS_LAT-1];
	assign clamped = !bad_depth && (cx || cy || wsat_q[AXIS_LAT-1]);

endmodule
`default_nettype wire

// ===== tb/sv/perspective_point_projection_tb.sv =====
`default_nettype none
module perspective_point_projection_tb;
	import ppp_pkg::*;

	typedef struct {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic [47:0]        w;
		logic               bad;
		logic               clamp;
		logic               last;
	} proj_t;

	class projection_board;
		logic signed [31:0] x_scale, y_scale, x_offset, y_offset;
		proj_t pending[$];
		int    errors;
		int    seen;
		int    bad_seen;
		int    clamp_seen;

		function void reset_regs();
			x_scale  = SCALE_ONE;
			y_scale  = SCALE_ONE;
			x_offset = 0;
			y_offset = 0;
		endfunction

		function void write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
			case (idx)
				REG_X_SCALE:  x_scale = val;
				REG_Y_SCALE:  y_scale = val;
				REG_X_OFFSET: x_offset = val;
				REG_Y_OFFSET: y_offset = val;
				default: ;
			endcase
		endfunction

		function logic [15:0] map_axis(logic signed [31:0] c, logic signed [31:0] s,
				logic signed [31:0] o, logic [47:0] w, inout bit cl);
			longint cc, ss, oo, p, sum, q;
			bit neg;
			logic [63:0] mc, ms, mag;
			logic [127:0] prod;
			cc = c;
			ss = s;
			oo = o;
			neg = (cc < 0) != (ss < 0);
			mc = (cc < 0) ? -cc : cc;
			ms = (ss < 0) ? -ss : ss;
			prod = {64'b0, mc * ms} * {80'b0, w};
			mag = prod[111:48];
			p = neg ? -longint'(mag) : longint'(mag);
			sum = p + oo;
			q = sum / 65536;
			if (q > 32767) begin
				q = 32767;
				cl = 1;
			end else if (q < -32768) begin
				q = -32768;
				cl = 1;
			end
			return q[15:0];
		endfunction

		function void note_request(logic signed [31:0] x, logic signed [31:0] y,
				logic signed [31:0] z, logic l);
			proj_t e;
			logic [63:0] w64;
			bit cl;
			cl = 0;
			e.last = l;
			if (z <= 0) begin
				e.sx = 0;
				e.sy = 0;
				e.w = 0;
				e.bad = 1;
				e.clamp = 0;
			end else begin
				w64 = 64'h1_0000_0000_0000 / {32'b0, z};
				if (w64 > 64'hFFFF_FFFF_FFFF) begin
					w64 = 64'hFFFF_FFFF_FFFF;
					cl = 1;
				end
				e.w = w64[47:0];
				e.sx = map_axis(x, x_scale, x_offset, e.w, cl);
				e.sy = map_axis(y, y_scale, y_offset, e.w, cl);
				e.bad = 0;
				e.clamp = cl;
			end
			pending.push_back(e);
		endfunction

		function void check_result(proj_t a);
			proj_t e;
			seen++;
			bad_seen += a.bad;
			clamp_seen += a.clamp;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected result sx=%0d sy=%0d w=%h", a.sx, a.sy, a.w);
				return;
			end
			e = pending.pop_front();
			if (a.sx !== e.sx || a.sy !== e.sy || a.w !== e.w || a.bad !== e.bad ||
					a.clamp !== e.clamp || a.last !== e.last) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: exp sx=%0d sy=%0d w=%h bad=%b clamp=%b last=%b",
						e.sx, e.sy, e.w, e.bad, e.clamp, e.last);
					$display("       got sx=%0d sy=%0d w=%h bad=%b clamp=%b last=%b",
						a.sx, a.sy, a.w, a.bad, a.clamp, a.last);
				end
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, last_point;
	logic signed [31:0] point_x, point_y, point_z;
	logic cfg_valid, cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic strobe, bad_depth, clamped, last_out;
	logic signed [15:0] screen_x, screen_y;
	logic [47:0] inv_depth;

	projection_board board;
	int sent;
	int phases;

	perspective_point_projection dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		proj_t r;
		if (arst_n && strobe) begin
			r.sx = screen_x;
			r.sy = screen_y;
			r.w = inv_depth;
			r.bad = bad_depth;
			r.clamp = clamped;
			r.last = last_out;
			board.check_result(r);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic l,
			int gap);
		repeat (gap) begin
			@(negedge clk);
			start = 0;
		end
		@(negedge clk);
		start = 1;
		point_x = x;
		point_y = y;
		point_z = z;
		last_point = l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_request(x, y, z, l);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		start = 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (AXIS_LAT + 60)
			@(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic logic [31:0] rand_depth();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return -$urandom_range(0, 1000);
		if (r < 11)
			return $urandom;
		if (r < 15)
			return $urandom_range(1, 4);
		return ($urandom >> $urandom_range(1, 28)) | 1;
	endfunction

	function automatic logic [31:0] rand_coord();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return $urandom;
		return $signed($urandom) >>> $urandom_range(4, 24);
	endfunction

	task automatic random_points(int n);
		repeat (n)
			send_point(rand_coord(), rand_coord(), rand_depth(), $urandom_range(0, 1),
				($urandom_range(0, 4) == 0) ? 0 : pick_gap());
	endtask

	task automatic set_all(logic [31:0] xs, logic [31:0] ys, logic [31:0] xo,
			logic [31:0] yo);
		write_cfg(REG_X_SCALE, xs);
		write_cfg(REG_Y_SCALE, ys);
		write_cfg(REG_X_OFFSET, xo);
		write_cfg(REG_Y_OFFSET, yo);
		phases++;
	endtask

	initial begin
		board = new();
		board.reset_regs();
		sent = 0;
		phases = 1;
		arst_n = 0;
		start = 0;
		point_x = 0;
		point_y = 0;
		point_z = 0;
		last_point = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Depth corners: unit raw depth saturates the reciprocal, zero and negative are bad.
		send_point(32'h0001_0000, 32'hFFFF_0000, 32'd1, 0, 0);
		send_point(32'h0000_0001, 32'h0000_0000, 32'd1, 1, 0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0);
		send_point(32'h1234_5678, 32'h8765_4321, 32'd0, 1, 0);
		send_point(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 0, 0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
		send_point(32'h0000_0000, 32'h0000_0000, 32'd2, 0, 0);
		send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 0, 0);
		send_point(32'hFFFF_FFFF, 32'h0000_FFFF, 32'd3, 1, 0);
		send_point(32'h7FFF_0000, 32'h8001_0000, 32'h7FFF_0000, 0, 0);
		send_point(32'h0040_0000, 32'hFFC0_0000, 32'h0000_8000, 1, 0);
		drain();
		random_points(140);
		drain();

		set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		write_cfg(3'd4, 32'hDEAD_BEEF);
		write_cfg(3'd7, 32'hFFFF_FFFF);
		random_points(140);
		drain();
		set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		random_points(140);
		drain();
		set_all(32'h0, 32'h0, 32'h0, 32'h0);
		random_points(60);
		drain();
		set_all(32'h0140_0000, 32'hFF10_0000, 32'h00A0_0000, 32'h0078_0000);
		write_cfg(3'd5, 32'h0);
		random_points(200);
		drain();
		repeat (3) begin
			set_all($urandom, $urandom, $urandom, $urandom);
			random_points(110);
			drain();
		end
		set_all(SCALE_ONE, SCALE_ONE, 32'h0, 32'h0);
		random_points(50);
		drain();

		$display("Ran %0d points over %0d register settings, %0d results checked.",
			sent, phases, board.seen);
		$display("Results with bad depth: %0d, with saturation: %0d.",
			board.bad_seen, board.clamp_seen);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("Mismatches: %0d, missing results: %0d", board.errors,
				board.pending.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
